/* rtl/sulaw_pkg.sv */
// Shared widths, constants and segment table for the scaled mu-law encoder.
`default_nettype none

package sulaw_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 16;
    localparam int CODE_W   = 8;
    localparam int GAIN_W   = 30;

    // Product of a signed sample and an unsigned gain, kept at full width
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int SCALE_SHIFT = 16;
    localparam int SCALED_W    = PROD_W - SCALE_SHIFT;

    // Magnitude inside the segment range (largest limit is 8158)
    localparam int MAG_W = 13;
    localparam int SEG_W = 3;
    localparam int SEG_N = 8;

    // Gain computation: 8192 * 65536 / peak, with unity gain for a zero peak
    localparam int                GAIN_NUM_BIT = 29;
    localparam logic [GAIN_W-1:0] GAIN_DEFAULT = GAIN_W'(65536);
    localparam logic [4:0]        DIV_STEPS_M1 = 5'(GAIN_NUM_BIT);

    // Largest magnitude that still lands in a segment
    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(8158);

    // Code for a magnitude past the last segment (sign bit added outside)
    localparam logic [CODE_W-2:0] CODE_SAT_LOW = '0;

    // Outer threshold of each positive segment
    function automatic logic [MAG_W-1:0] seg_limit(input logic [SEG_W-1:0] k);
        logic [MAG_W-1:0] lim;
        case (k)
            3'd0:    lim = MAG_W'(30);
            3'd1:    lim = MAG_W'(94);
            3'd2:    lim = MAG_W'(222);
            3'd3:    lim = MAG_W'(478);
            3'd4:    lim = MAG_W'(990);
            3'd5:    lim = MAG_W'(2014);
            3'd6:    lim = MAG_W'(4062);
            default: lim = MAG_W'(8158);
        endcase
        return lim;
    endfunction

    // Segment search result handed between the two encoder stages
    typedef struct packed {
        logic             sign;
        logic             over;
        logic [SEG_W-1:0] seg;
        logic [MAG_W-1:0] mag;
    } t_seg;

endpackage

`default_nettype wire

/* rtl/sulaw_gain_div.sv */
// Gain coefficient unit: restoring divider, one quotient bit per cycle.
`default_nettype none

module sulaw_gain_div
    import sulaw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [PEAK_W-1:0] i_wr_data,
    output logic                   o_busy,
    output logic [GAIN_W-1:0]      o_gain
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [PEAK_W-1:0] r_div;
    logic [PEAK_W-1:0] r_rem;
    logic [GAIN_W-1:0] r_quo;
    logic [GAIN_W-1:0] r_gain;

    logic [PEAK_W:0]   n_rem_sh;
    logic              n_qbit;
    logic [PEAK_W-1:0] n_rem;
    logic [GAIN_W-1:0] n_quo;

    // One restoring step; the dividend has only its top bit set
    always_comb begin
        n_rem_sh = {r_rem, (r_cnt == DIV_STEPS_M1)};
        n_qbit   = (n_rem_sh >= {1'b0, r_div});
        n_rem    = n_qbit ? PEAK_W'(n_rem_sh - {1'b0, r_div}) : n_rem_sh[PEAK_W-1:0];
        n_quo    = {r_quo[GAIN_W-2:0], n_qbit};
    end

    // Sequencer: load on write, step until the last quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_gain <= GAIN_DEFAULT;
        end else if (i_wr_en) begin
            if (i_wr_data == '0) begin
                r_busy <= 1'b0;
                r_gain <= GAIN_DEFAULT;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS_M1;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_gain <= n_quo;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_div <= i_wr_data;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_gain = r_gain;

endmodule

`default_nettype wire

/* rtl/sulaw_scale.sv */
// Scaling stages: input register, then full-width sample-by-gain product.
`default_nettype none

module sulaw_scale
    import sulaw_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [GAIN_W-1:0]          i_gain,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [PROD_W-1:0]        o_prod
);

    logic                       r_in_v;
    logic signed [SAMPLE_W-1:0] r_in_s;
    logic                       r_p_v;
    logic signed [PROD_W-1:0]   r_p;

    logic rdy_p;
    logic rdy_in;

    // Each stage moves when it is empty or the next one takes its word
    assign rdy_p   = !r_p_v || i_ready;
    assign rdy_in  = !r_in_v || rdy_p;
    assign o_ready = rdy_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_p_v  <= 1'b0;
        end else begin
            if (rdy_in) r_in_v <= i_valid;
            if (rdy_p)  r_p_v  <= r_in_v;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (rdy_in && i_valid) r_in_s <= i_sample;
    end

    // Signed sample times unsigned gain
    always_ff @(posedge i_clk) begin
        if (rdy_p && r_in_v) r_p <= PROD_W'(r_in_s * $signed({1'b0, i_gain}));
    end

    assign o_valid = r_p_v;
    assign o_prod  = r_p;

endmodule

`default_nettype wire

/* rtl/sulaw_segment.sv */
// Encoder stages: segment search, then step count and output code register.
`default_nettype none

module sulaw_segment
    import sulaw_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [PROD_W-1:0] i_prod,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [CODE_W-1:0]             o_code
);

    logic              r_a_v;
    t_seg              r_a;
    logic              r_b_v;
    logic [CODE_W-1:0] r_b_code;

    logic rdy_b;
    logic rdy_a;

    logic [SCALED_W-1:0] v;
    logic [SCALED_W-1:0] u;
    t_seg                n_a;
    logic [SEG_W-1:0]    cnt;

    logic [MAG_W-1:0]  lim;
    logic [MAG_W-1:0]  span;
    logic [MAG_W-1:0]  steps;
    logic [CODE_W-1:0] n_code;

    // Handshake between stages
    assign rdy_b   = !r_b_v || i_ready;
    assign rdy_a   = !r_a_v || rdy_b;
    assign o_ready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_valid;
            if (rdy_b) r_b_v <= r_a_v;
        end
    end

    // Floor shift, fold negatives onto ones' complement, find the segment
    always_comb begin
        v   = i_prod[PROD_W-1:SCALE_SHIFT];
        u   = v[SCALED_W-1] ? ~v : v;
        cnt = '0;
        for (int j = 0; j < SEG_N - 1; j++) begin
            cnt = cnt + SEG_W'(u[MAG_W-1:0] > seg_limit(SEG_W'(j)));
        end
        n_a.sign = v[SCALED_W-1];
        n_a.over = (u[SCALED_W-1:MAG_W] != '0) || (u[MAG_W-1:0] > MAG_LIMIT);
        n_a.seg  = cnt;
        n_a.mag  = u[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) r_a <= n_a;
    end

    // Step count inside the segment; bits 6:4 hold the inverted segment
    always_comb begin
        lim    = seg_limit(r_a.seg);
        span   = lim - r_a.mag;
        steps  = span >> ({1'b0, r_a.seg} + 4'd1);
        n_code = {~r_a.sign, r_a.over ? CODE_SAT_LOW : {~r_a.seg, steps[3:0]}};
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_a_v) r_b_code <= n_code;
    end

    assign o_valid = r_b_v;
    assign o_code  = r_b_code;

endmodule

`default_nettype wire

/* rtl/scaled_ulaw_encoder.sv */
// Top level of the scaled mu-law encoder: gain unit, scaling and encoding pipeline.
//
//  Channel     Direction  Word contents (low bit up)
//  s_axis      in         tdata[15:0] sample, signed PCM
//  m_axis      out        tdata[7:0]  ulaw_code
//  cfg         in         i_cfg_wr_data[15:0] peak_level, written when i_cfg_wr_en
//
//  One word per cycle unless the divider is busy or m_axis stalls.
//  Four register stages: input, 16x31 multiply, segment search, code output.
//  A nonzero peak write starts the divider (one quotient bit per cycle);
//  s_axis_tready is low until it ends. A zero peak sets unity gain at once.
//  Reset clears all valid bits and sets unity gain. Each stage holds its word
//  under stall and takes a new one as soon as it empties, so bubbles fill in.
`default_nettype none

module scaled_ulaw_encoder
    import sulaw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [PEAK_W-1:0]   i_cfg_wr_data,  // [15:0] peak_level
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [CODE_W-1:0]        m_axis_tdata    // [7:0] ulaw_code
);

    logic                     busy;
    logic [GAIN_W-1:0]        gain;
    logic                     scale_ready;
    logic                     prod_valid;
    logic                     prod_ready;
    logic signed [PROD_W-1:0] prod;

    // Gain coefficient
    sulaw_gain_div u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_wr_data (i_cfg_wr_data),
        .o_busy    (busy),
        .o_gain    (gain)
    );

    // No word enters while the gain is being worked out
    assign s_axis_tready = scale_ready && !busy;

    sulaw_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (gain),
        .i_valid  (s_axis_tvalid && !busy),
        .o_ready  (scale_ready),
        .i_sample ($signed(s_axis_tdata)),
        .o_valid  (prod_valid),
        .i_ready  (prod_ready),
        .o_prod   (prod)
    );

    sulaw_segment u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_code  (m_axis_tdata)
    );

endmodule

`default_nettype wire
